@@ hdl/aept_pkg.sv @@
// package for the absolute encoder position tracker
// sizes, operation codes and controller states; no dependencies
package aept_pkg;

  localparam int MaxPositions = 128;
  localparam int IdxW         = $clog2(MaxPositions);
  localparam int CntW         = $clog2(MaxPositions + 1);
  localparam int CodeW        = 8;
  localparam int RevDepth     = 1 << CodeW;

  localparam logic [CodeW-1:0] CodeAllOnes = '1;
  localparam logic [CodeW-1:0] CodeNone    = '0;
  localparam logic [7:0]       PosReset    = 8'd128;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LEARN = 2'd1,
    FUNC_TRACK = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_REV,
    ST_FWD
  } state_e;

endpackage

@@ hdl/absolute_encoder_position_tracker_core.sv @@
// absolute encoder position tracker: learned code table with reverse lookup
// depends on aept_pkg; holds the forward and reverse table memories
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------------
//  in      | func_i, code_i                            | in_valid_i / in_stall_o
//  out     | position_o, found_o, moved_o, direction_o,| out_valid_o / out_stall_i
//          | learned_count_o, table_full_o             |
//  cfg     | cfg_wdata_i                               | cfg_we_i
//
// each item passes through accept and reverse-memory read (code to index),
// forward-memory read (index to code), then check and write-back; no new item is taken until that is done.
// after reset the reverse memory is swept to zero, one entry a cycle, over
// all 256 entries; no item is accepted during the sweep, config writes are taken.
// a finished result waits in the output register while the next item runs;
// the write-back step holds while that register is still stalled.
module absolute_encoder_position_tracker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                func_i,
  input  logic [aept_pkg::CodeW-1:0] code_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [aept_pkg::IdxW-1:0] position_o,
  output logic                      found_o,
  output logic                      moved_o,
  output logic                      direction_o,
  output logic [aept_pkg::CntW-1:0] learned_count_o,
  output logic                      table_full_o
);
  import aept_pkg::*;

  // table memories: fwd holds index -> code, rev holds code -> index
  logic [CodeW-1:0] fwd_mem [MaxPositions];
  logic [IdxW-1:0]  rev_mem [RevDepth];

  state_e state_q, state_d;
  logic [CodeW-1:0] init_cnt_q;
  logic [7:0]       pos_q;
  logic [CntW-1:0]  stored_q, stored_d;
  logic [IdxW-1:0]  last_q, last_d;
  logic             rot_q, rot_d;
  func_e            func_q;
  logic [CodeW-1:0] code_q;

  logic [IdxW-1:0]  rev_rdata_q;
  logic [CodeW-1:0] fwd_rdata_q;

  logic             out_valid_q;
  logic [IdxW-1:0]  position_q;
  logic             found_q, found_d;
  logic             moved_q, moved_d;
  logic             direction_q;
  logic [CntW-1:0]  learned_q;
  logic             full_q;

  logic             in_accept, out_free, commit;
  logic             rev_re, fwd_re, rev_we, fwd_we;
  logic [CodeW-1:0] rev_raddr, rev_waddr, code_in;
  logic [IdxW-1:0]  rev_wdata;
  logic [CntW-1:0]  eff, lim, last_idx;
  logic             hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_FWD) && out_free;

  // learn folds the all-ones code onto the empty code
  assign code_in = ((func_e'(func_i) == FUNC_LEARN) && (code_i == CodeAllOnes))
                   ? CodeNone : code_i;

  always_comb begin
    if (pos_q == 8'd0) begin
      eff = CntW'(1);
    end else if (CntW'(pos_q) > CntW'(MaxPositions)) begin
      eff = CntW'(MaxPositions);
    end else begin
      eff = CntW'(pos_q);
    end
  end

  assign lim      = (stored_q < eff) ? stored_q : eff;
  assign last_idx = eff - CntW'(1);
  // a reverse entry counts only if it points inside the filled part and
  // the forward entry there agrees
  assign hit      = (CntW'(rev_rdata_q) < lim) && (fwd_rdata_q == code_q);

  // write-back happens the cycle before idle, so the next item's reads
  // never overlap a pending write to the same entry
  assign rev_re    = in_accept;
  assign rev_raddr = code_in;
  assign fwd_re    = (state_q == ST_REV);

  always_comb begin
    state_d   = state_q;
    stored_d  = stored_q;
    last_d    = last_q;
    rot_d     = rot_q;
    found_d   = 1'b0;
    moved_d   = 1'b0;
    fwd_we    = 1'b0;
    rev_we    = 1'b0;
    rev_waddr = code_q;
    rev_wdata = stored_q[IdxW-1:0];
    unique case (state_q)
      ST_INIT: begin
        rev_we    = 1'b1;
        rev_waddr = init_cnt_q;
        rev_wdata = '0;
        if (init_cnt_q == CodeAllOnes) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_REV;
        end
      end
      ST_REV: begin
        state_d = ST_FWD;
      end
      ST_FWD: begin
        if (commit) begin
          state_d = ST_IDLE;
          unique case (func_q)
            FUNC_CLEAR: begin
              stored_d = '0;
            end
            FUNC_LEARN: begin
              if ((code_q != CodeNone) && (stored_q < eff) && !hit) begin
                fwd_we   = 1'b1;
                rev_we   = 1'b1;
                stored_d = stored_q + CntW'(1);
              end
            end
            FUNC_TRACK: begin
              if (hit) begin
                found_d = 1'b1;
                if (rev_rdata_q != last_q) begin
                  moved_d = 1'b1;
                  last_d  = rev_rdata_q;
                  priority if ((last_q == '0) && (CntW'(rev_rdata_q) == last_idx)) begin
                    rot_d = 1'b0;
                  end else if ((CntW'(last_q) == last_idx) && (rev_rdata_q == '0)) begin
                    rot_d = 1'b1;
                  end else if (rev_rdata_q < last_q) begin
                    rot_d = 1'b0;
                  end else begin
                    rot_d = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rev_re) begin
      rev_rdata_q <= rev_mem[rev_raddr];
    end
    if (rev_we) begin
      rev_mem[rev_waddr] <= rev_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwd_re) begin
      fwd_rdata_q <= fwd_mem[rev_rdata_q];
    end
    if (fwd_we) begin
      fwd_mem[stored_q[IdxW-1:0]] <= code_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      pos_q       <= PosReset;
      stored_q    <= '0;
      last_q      <= '0;
      rot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      stored_q <= stored_d;
      last_q   <= last_d;
      rot_q    <= rot_d;
      if (state_q == ST_INIT) begin
        init_cnt_q <= init_cnt_q + CodeW'(1);
      end
      if (cfg_we_i) begin
        pos_q <= cfg_wdata_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_e'(func_i);
      code_q <= code_in;
    end
    if (commit) begin
      position_q  <= last_d;
      found_q     <= found_d;
      moved_q     <= moved_d;
      direction_q <= rot_d;
      learned_q   <= stored_d;
      full_q      <= (stored_d >= eff);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign position_o      = position_q;
  assign found_o         = found_q;
  assign moved_o         = moved_q;
  assign direction_o     = direction_q;
  assign learned_count_o = learned_q;
  assign table_full_o    = full_q;

`ifndef ASSERT_OFF
  a_moved_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && moved_o) |-> found_o)
    else $error("moved reported without a table match");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CntW'(MaxPositions))
    else $error("stored code count beyond table depth");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (learned_count_o != '0))
    else $error("table reported full while empty");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> in_stall_o)
    else $error("item accepted during reverse memory sweep");
`endif

endmodule
